/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks used in the RTL folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// The consequent must hold in the cycle after the antecedent, reset included.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("reset check failed");

`endif

/* hw/rtl/epsm_pkg.sv */
// ----------------------------------------------------------------------------
// Encoder period speed meter package
// Types and constants shared by the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package epsm_pkg;

   localparam int SCALE_BITS    = 24;
   localparam int ALPHA_BITS    = 16;
   localparam int OUT_BITS      = 32;
   localparam int DIV_STEPS     = SCALE_BITS;
   localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 24;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 136;

   localparam logic [CSR_IDX_BITS-1:0] CSR_INVERT_DIRECTION = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPEED_SCALE      = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FILTER_ALPHA     = 2'd2;

   localparam logic [SCALE_BITS-1:0] SPEED_SCALE_RESET  = 24'd4416703;
   localparam logic [ALPHA_BITS-1:0] FILTER_ALPHA_RESET = 16'd10486;

   typedef struct packed {
      logic start_edge;
      logic start_sample;
      logic div_step;
      logic speed;
      logic mul;
      logic filt;
      logic load_out;
   } cmd_type;

endpackage

/* hw/rtl/epsm_ctrl.sv */
// ----------------------------------------------------------------------------
// Encoder period speed meter controller
// Sequences one item to the result register, samples via division and filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epsm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               req_func,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output epsm_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SPEED,
      ST_MULTIPLY,
      ST_FILTER,
      ST_HOLD
   } state_type;

   state_type                            state_ff;
   state_type                            state_in;
   logic [epsm_pkg::DIV_CNT_BITS-1:0]    cnt_ff;
   logic [epsm_pkg::DIV_CNT_BITS-1:0]    cnt_in;
   logic                                 valid_ff;
   logic                                 valid_in;
   logic                                 accept;
   logic                                 load;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign load       = (state_ff == ST_HOLD) && (!valid_ff || rsp_tready);

   always_comb begin
      cmd              = '0;
      cmd.start_edge   = accept && !req_func;
      cmd.start_sample = accept && req_func;
      cmd.div_step     = (state_ff == ST_DIVIDE);
      cmd.speed        = (state_ff == ST_SPEED);
      cmd.mul          = (state_ff == ST_MULTIPLY);
      cmd.filt         = (state_ff == ST_FILTER);
      cmd.load_out     = load;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = req_func ? ST_DIVIDE : ST_HOLD;
            end
         end
         ST_DIVIDE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (epsm_pkg::DIV_CNT_BITS)'(epsm_pkg::DIV_STEPS - 1)) begin
               state_in = ST_SPEED;
            end
         end
         ST_SPEED:    state_in = ST_MULTIPLY;
         ST_MULTIPLY: state_in = ST_FILTER;
         ST_FILTER:   state_in = ST_HOLD;
         ST_HOLD: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule

/* hw/rtl/epsm_datapath.sv */
// ----------------------------------------------------------------------------
// Encoder period speed meter datapath
// Position and edge time state, period choice, shift-subtract divider,
// exponential filter and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epsm_datapath #(
   parameter int TIME_BITS  = 32,
   parameter int COUNT_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  epsm_pkg::cmd_type                    cmd,
   input  logic                                 csr_we,
   input  logic [epsm_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [epsm_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic [epsm_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output logic [epsm_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);

   localparam int SB   = epsm_pkg::SCALE_BITS;
   localparam int OB   = epsm_pkg::OUT_BITS;
   localparam int DW   = ((TIME_BITS > SB) ? TIME_BITS : SB) + 1;
   localparam int PW   = epsm_pkg::ALPHA_BITS + OB + 2;
   localparam int PAD  = epsm_pkg::RSP_DATA_BITS - (4 * OB + 1);

   logic                          invert_ff;
   logic [SB-1:0]                 scale_ff;
   logic [epsm_pkg::ALPHA_BITS-1:0] alpha_ff;

   logic [COUNT_BITS-1:0]         count_ff;
   logic                          dir_neg_ff;
   logic                          rev_ff;
   logic [TIME_BITS-1:0]          last_ff;
   logic [TIME_BITS-1:0]          prev_ff;
   logic signed [OB-1:0]          smooth_ff;

   logic                          kind_ff;
   logic [TIME_BITS-1:0]          period_ff;
   logic [DW-1:0]                 rem_ff;
   logic [SB-1:0]                 quo_ff;
   logic signed [OB-1:0]          raw_ff;
   logic signed [PW-1:0]          prod_ff;

   logic                          phase_b;
   logic [TIME_BITS-1:0]          now_t;
   logic [TIME_BITS-1:0]          gap;
   logic [TIME_BITS-1:0]          since;
   logic                          fwd;
   logic [DW-1:0]                 trial;
   logic [DW-1:0]                 per_ext;
   logic                          fits;
   logic signed [OB:0]            diff;
   logic signed [PW-1:0]          biased;
   logic signed [PW-1:0]          q;
   logic [63:0]                   period_w;
   logic [OB-1:0]                 period_out;
   logic signed [OB-1:0]          position;

   assign phase_b  = req_tdata[0];
   assign now_t    = TIME_BITS'(req_tdata[OB:1]);
   assign gap      = last_ff - prev_ff;
   assign since    = now_t - last_ff;
   assign fwd      = phase_b ^ invert_ff;
   assign per_ext  = DW'(period_ff);
   assign trial    = {rem_ff[DW-2:0], quo_ff[SB-1]};
   assign fits     = (trial >= per_ext);
   assign diff     = (OB + 1)'(raw_ff) - (OB + 1)'(smooth_ff);
   assign biased   = prod_ff + PW'(32768);
   assign q        = biased >>> 16;
   assign period_w = 64'(period_ff);
   assign period_out = (period_w > 64'hFFFF_FFFF) ? '1 : period_w[OB-1:0];
   assign position = OB'($signed(count_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff <= 1'b0;
         scale_ff  <= epsm_pkg::SPEED_SCALE_RESET;
         alpha_ff  <= epsm_pkg::FILTER_ALPHA_RESET;
      end else if (csr_we) begin
         case (csr_index)
            epsm_pkg::CSR_INVERT_DIRECTION: invert_ff <= csr_wdata[0];
            epsm_pkg::CSR_SPEED_SCALE:      scale_ff  <= csr_wdata[SB-1:0];
            epsm_pkg::CSR_FILTER_ALPHA:
               alpha_ff <= csr_wdata[epsm_pkg::ALPHA_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dir_neg_ff <= 1'b0;
         rev_ff     <= 1'b0;
         last_ff    <= '0;
         prev_ff    <= '0;
         smooth_ff  <= '0;
      end else begin
         if (cmd.start_edge) begin
            prev_ff    <= last_ff;
            last_ff    <= now_t;
            dir_neg_ff <= !fwd;
            rev_ff     <= fwd ? dir_neg_ff : !dir_neg_ff;
            count_ff   <= fwd ? (count_ff + 1'b1) : (count_ff - 1'b1);
         end
         if (cmd.filt) begin
            smooth_ff <= smooth_ff + q[OB-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_edge) begin
         kind_ff   <= 1'b0;
         raw_ff    <= '0;
         period_ff <= '0;
      end
      if (cmd.start_sample) begin
         kind_ff   <= 1'b1;
         period_ff <= (gap > since) ? gap : since;
         rem_ff    <= '0;
         quo_ff    <= scale_ff;
      end
      if (cmd.div_step) begin
         rem_ff <= fits ? (trial - per_ext) : trial;
         quo_ff <= {quo_ff[SB-2:0], fits};
      end
      if (cmd.speed) begin
         if (rev_ff || (period_ff == '0)) begin
            raw_ff <= '0;
         end else if (dir_neg_ff) begin
            raw_ff <= -OB'(quo_ff);
         end else begin
            raw_ff <= OB'(quo_ff);
         end
      end
      if (cmd.mul) begin
         prod_ff <= PW'($signed({1'b0, alpha_ff}) * diff);
      end
      if (cmd.load_out) begin
         rsp_tdata <= {PAD'(0),
                       kind_ff ? period_out : OB'(0),
                       rev_ff,
                       smooth_ff,
                       raw_ff,
                       position};
      end
   end

endmodule

/* hw/rtl/encoder_period_speed_meter.sv */
// ----------------------------------------------------------------------------
// Encoder period speed meter
// One wheel's quadrature position count and period-method speed estimate.
// ----------------------------------------------------------------------------
// The request stream carries one beat per event. With req_tuser low the beat
// is a rising A edge: the B level moves the position count and shifts the edge
// times. With req_tuser high the beat asks for a speed sample at now_us.
// Every request beat returns exactly one response beat with the count, the raw
// and filtered speed in rad/s Q.8, the reversal flag and the chosen period.
// An edge beat goes straight to the response register load. A sample beat
// first runs the one-bit-per-cycle divider, then the sign, multiply and
// filter update steps, and then loads the response register.
// One beat is in work at a time; a new request is taken in the cycle after the
// result enters the response register, even while that response is stalled.
// A stalled response holds its beat, and the next result waits behind it.
// Reset clears the count, edge times and filter, sets forward rotation and
// loads the register defaults. The user writes registers through csr_* only
// while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_period_speed_meter #(
   parameter int TIME_BITS  = 32,
   parameter int COUNT_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // Fields from bit 0: phase_b, now_us.
   input  logic [epsm_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // Fields from bit 0: func.
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // Fields from bit 0: position_count, speed_raw, speed_filtered,
   // reversing, period_us.
   output logic [epsm_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                 csr_we,
   input  logic [epsm_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [epsm_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   epsm_pkg::cmd_type cmd;

   epsm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   epsm_datapath #(
      .TIME_BITS  (TIME_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

/* hw/rtl/epsm_checker.sv */
// ----------------------------------------------------------------------------
// Encoder period speed meter checker
// Port-level checks on the request and response streams, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module epsm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [epsm_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);

   logic        rsp_wait;
   logic        rsp_zero_period;
   logic        rsp_rev;
   logic        rsp_raw_zero;

   assign rsp_wait        = rsp_tvalid && !rsp_tready;
   assign rsp_zero_period = rsp_tvalid && (rsp_tdata[128:97] == 32'd0);
   assign rsp_rev         = rsp_tvalid && rsp_tdata[96];
   assign rsp_raw_zero    = (rsp_tdata[63:32] == 32'd0);

   `ASSERT_NEXT_ALWAYS(a_reset_clears_rsp, clock, reset, !rsp_tvalid)

   `ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_wait, rsp_tvalid && $stable(rsp_tdata))

   `ASSERT_NEXT(a_one_in_work, clock, reset, req_tvalid && req_tready, !req_tready)

   `ASSERT_SAME(a_zero_period_no_speed, clock, reset, rsp_zero_period, rsp_raw_zero)

   `ASSERT_SAME(a_reversal_no_speed, clock, reset, rsp_rev, rsp_raw_zero)

endmodule

bind encoder_period_speed_meter epsm_checker u_epsm_checker (.*);

/* tb/sv/encoder_period_speed_meter_tb.sv */
// ----------------------------------------------------------------------------
// Encoder period speed meter testbench
// Sends encoder edge and speed sample beats through the request stream while
// an in-bench copy of the meter predicts every response beat. The bench checks
// each response field by field. The run walks through several register
// settings, random sender bursts, receiver stalls and one long receiver hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_period_speed_meter_tb;

   localparam logic FUNC_EDGE   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   localparam int FWD_STEADY = 1;
   localparam int FWD_TURN   = 2;
   localparam int REV_STEADY = -1;
   localparam int REV_TURN   = -2;

   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic        func;
      logic        phase_b;
      logic [31:0] now_us;
   } encoder_event_type;

   typedef struct packed {
      logic [31:0] position;
      logic [31:0] speed_raw;
      logic [31:0] speed_filt;
      logic        reversing;
      logic [31:0] period;
   } meter_reading_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [epsm_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                               req_tuser = 1'b0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [epsm_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                               csr_we = 1'b0;
   logic [epsm_pkg::CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [epsm_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   encoder_period_speed_meter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Register copies used for prediction.
   logic                            cfg_invert = 1'b0;
   logic [epsm_pkg::SCALE_BITS-1:0] cfg_scale  = epsm_pkg::SPEED_SCALE_RESET;
   logic [epsm_pkg::ALPHA_BITS-1:0] cfg_alpha  = epsm_pkg::FILTER_ALPHA_RESET;

   // Wheel state as the meter should hold it.
   logic [31:0] pos_count    = '0;
   int          dir_code     = FWD_STEADY;
   logic [31:0] last_edge_us = '0;
   logic [31:0] prev_edge_us = '0;
   int          smooth_speed = 0;

   encoder_event_type pending_events[$];
   meter_reading_type expected_readings[$];
   int                queued_count   = 0;
   int                accepted_count = 0;
   int                mismatches     = 0;

   logic sender_gaps     = 1'b1;
   logic receiver_stalls = 1'b1;
   int   hold_wanted     = 0;
   int   hold_seen       = 0;
   int   hold_left       = 0;
   int   burst_left      = 0;
   int   gap_left        = 0;

   logic [31:0] gen_time = '0;
   logic        gen_dir  = 1'b1;

   function automatic meter_reading_type meter_step(logic func, logic phase_b,
                                                    logic [31:0] now_us);
      meter_reading_type r;
      logic [31:0]       gap;
      logic [31:0]       since;
      logic [31:0]       period;
      logic [31:0]       quot;
      int                raw;
      longint            weight;
      longint            prod;
      longint            delta;
      raw = 0;
      period = '0;
      if (func == FUNC_EDGE) begin
         prev_edge_us = last_edge_us;
         last_edge_us = now_us;
         if (phase_b ^ cfg_invert) begin
            pos_count = pos_count + 32'd1;
            dir_code = (dir_code < 0) ? FWD_TURN : FWD_STEADY;
         end else begin
            pos_count = pos_count - 32'd1;
            dir_code = (dir_code > 0) ? REV_TURN : REV_STEADY;
         end
      end else begin
         gap = last_edge_us - prev_edge_us;
         since = now_us - last_edge_us;
         period = (gap > since) ? gap : since;
         if (dir_code != FWD_TURN && dir_code != REV_TURN && period != 0) begin
            quot = {8'd0, cfg_scale} / period;
            raw = quot;
            if (dir_code < 0) begin
               raw = -raw;
            end
         end
         // Rounded step toward the raw speed, ties toward plus infinity.
         weight = longint'(cfg_alpha);
         prod = weight * (longint'(raw) - longint'(smooth_speed));
         delta = (prod + 64'sd32768) >>> 16;
         smooth_speed = int'(longint'(smooth_speed) + delta);
      end
      r.position   = pos_count;
      r.speed_raw  = raw;
      r.speed_filt = smooth_speed;
      r.reversing  = (dir_code == FWD_TURN || dir_code == REV_TURN);
      r.period     = period;
      return r;
   endfunction

   always @(posedge clock) begin : drive_requests
      logic              busy;
      encoder_event_type ev;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         busy = req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_readings.push_back(meter_step(req_tuser, req_tdata[0],
                                                   req_tdata[32:1]));
            accepted_count++;
            busy = 1'b0;
         end
         if (!busy) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_events.size() > 0) begin
               ev = pending_events.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {7'd0, ev.now_us, ev.phase_b};
               req_tuser  <= ev.func;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = sender_gaps ? $urandom_range(0, 15) : 0;
               end
               burst_left--;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : drive_rsp_ready
      logic [15:0] stall_bits;
      int          stall_phase;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_bits = '1;
         stall_phase = 0;
      end else begin
         if (hold_seen != hold_wanted) begin
            hold_seen = hold_wanted;
            hold_left = HOLD_CYCLES;
         end
         if (stall_phase == 0) begin
            stall_bits = 16'($urandom());
            if ($urandom_range(0, 1) == 1) begin
               stall_bits = stall_bits | 16'($urandom());
            end
         end
         stall_phase = (stall_phase + 1) % 16;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!receiver_stalls) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= stall_bits[stall_phase];
         end
      end
   end

   task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch on %s: expected %h, got %h at %0t", what, want, got,
                  $realtime);
      end
   endtask

   always @(posedge clock) begin : check_responses
      meter_reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_readings.size() == 0) begin
            note_mismatch("unrequested beat", '0, rsp_tdata[31:0]);
         end else begin
            want = expected_readings.pop_front();
            if (rsp_tdata[31:0] !== want.position) begin
               note_mismatch("position_count", want.position, rsp_tdata[31:0]);
            end
            if (rsp_tdata[63:32] !== want.speed_raw) begin
               note_mismatch("speed_raw", want.speed_raw, rsp_tdata[63:32]);
            end
            if (rsp_tdata[95:64] !== want.speed_filt) begin
               note_mismatch("speed_filtered", want.speed_filt, rsp_tdata[95:64]);
            end
            if (rsp_tdata[96] !== want.reversing) begin
               note_mismatch("reversing", 32'(want.reversing), 32'(rsp_tdata[96]));
            end
            if (rsp_tdata[128:97] !== want.period) begin
               note_mismatch("period_us", want.period, rsp_tdata[128:97]);
            end
         end
      end
   end

   task automatic write_reg(logic [epsm_pkg::CSR_IDX_BITS-1:0] idx,
                            logic [epsm_pkg::CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         epsm_pkg::CSR_INVERT_DIRECTION: cfg_invert = val[0];
         epsm_pkg::CSR_SPEED_SCALE:      cfg_scale  = val[epsm_pkg::SCALE_BITS-1:0];
         epsm_pkg::CSR_FILTER_ALPHA:     cfg_alpha  = val[epsm_pkg::ALPHA_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_all(logic inv, logic [epsm_pkg::SCALE_BITS-1:0] scale,
                            logic [epsm_pkg::ALPHA_BITS-1:0] alpha);
      write_reg(epsm_pkg::CSR_INVERT_DIRECTION, {23'd0, inv});
      write_reg(epsm_pkg::CSR_SPEED_SCALE, scale);
      write_reg(epsm_pkg::CSR_FILTER_ALPHA, {8'd0, alpha});
   endtask

   task automatic push_event(logic func, logic phase_b, logic [31:0] now_us);
      encoder_event_type ev;
      ev.func = func;
      ev.phase_b = phase_b;
      ev.now_us = now_us;
      pending_events.push_back(ev);
      queued_count++;
   endtask

   task automatic wait_meter_idle();
      do begin
         @(posedge clock);
      end while (accepted_count != queued_count || expected_readings.size() != 0);
   endtask

   // Mostly plausible wheel motion with occasional turns, plus some noise beats.
   task automatic queue_motion(int count);
      logic [31:0] step;
      if ($urandom_range(0, 3) == 0) begin
         gen_time = $urandom();
      end else begin
         gen_time = gen_time + $urandom_range(0, 1000000);
      end
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 99) < 12) begin
            push_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
         end else begin
            if ($urandom_range(0, 19) == 0) begin
               gen_dir = ~gen_dir;
            end
            case ($urandom_range(0, 4))
               0: step = $urandom_range(1, 20);
               1: step = $urandom_range(20, 2000);
               2: step = $urandom_range(2000, 100000);
               3: step = $urandom_range(100000, 50000000);
               default: step = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 500);
            endcase
            gen_time = gen_time + step;
            if ($urandom_range(0, 2) == 0) begin
               push_event(FUNC_SAMPLE, 1'($urandom_range(0, 1)), gen_time);
            end else begin
               push_event(FUNC_EDGE, gen_dir ^ cfg_invert, gen_time);
            end
         end
      end
   endtask

   task automatic random_config();
      logic [epsm_pkg::SCALE_BITS-1:0] scale;
      if ($urandom_range(0, 1) == 1) begin
         scale = 24'($urandom_range(1, 24'hFFFFFF));
      end else begin
         scale = 24'($urandom_range(1, 5000));
      end
      write_all(1'($urandom_range(0, 1)), scale, 16'($urandom_range(0, 65535)));
   endtask

   initial begin : run_phases
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed beats under the reset register values.
      push_event(FUNC_SAMPLE, 1'b0, 32'h0000_0000);
      push_event(FUNC_SAMPLE, 1'b1, 32'hFFFF_FFFF);
      push_event(FUNC_EDGE,   1'b1, 32'd1000);
      push_event(FUNC_EDGE,   1'b1, 32'd2000);
      push_event(FUNC_SAMPLE, 1'b0, 32'd2500);
      push_event(FUNC_SAMPLE, 1'b1, 32'd9000);
      push_event(FUNC_EDGE,   1'b0, 32'd10000);
      push_event(FUNC_SAMPLE, 1'b0, 32'd10100);
      push_event(FUNC_EDGE,   1'b0, 32'd10500);
      push_event(FUNC_SAMPLE, 1'b0, 32'd10600);
      push_event(FUNC_EDGE,   1'b1, 32'd11000);
      push_event(FUNC_EDGE,   1'b1, 32'd11001);
      push_event(FUNC_SAMPLE, 1'b0, 32'd11001);
      push_event(FUNC_EDGE,   1'b1, 32'hFFFF_FF00);
      push_event(FUNC_EDGE,   1'b1, 32'h0000_0080);
      push_event(FUNC_SAMPLE, 1'b0, 32'h0000_00C0);
      push_event(FUNC_EDGE,   1'b1, 32'h0000_0080);
      push_event(FUNC_SAMPLE, 1'b0, 32'h0000_0080);
      push_event(FUNC_EDGE,   1'b0, 32'h7FFF_FFFF);
      push_event(FUNC_EDGE,   1'b0, 32'h8000_0000);
      push_event(FUNC_SAMPLE, 1'b0, 32'hFFFF_FFFF);
      wait_meter_idle();

      // Largest register values, no idling on either side.
      sender_gaps <= 1'b0;
      receiver_stalls <= 1'b0;
      write_all(1'b1, 24'hFFFFFF, 16'hFFFF);
      queue_motion(100);
      wait_meter_idle();

      // Smallest nonzero scale, zero alpha and no inversion, with idling.
      sender_gaps <= 1'b1;
      receiver_stalls <= 1'b1;
      write_all(1'b0, 24'd1, 16'd0);
      queue_motion(100);
      wait_meter_idle();

      // A zero scale must give no raw speed.
      write_reg(epsm_pkg::CSR_SPEED_SCALE, 24'd0);
      write_reg(epsm_pkg::CSR_FILTER_ALPHA, 24'($urandom_range(0, 65535)));
      push_event(FUNC_EDGE,   1'b1, 32'd50000);
      push_event(FUNC_EDGE,   1'b1, 32'd50100);
      push_event(FUNC_SAMPLE, 1'b0, 32'd50150);
      queue_motion(40);
      wait_meter_idle();

      // The receiver holds off long enough for the input side to back up.
      sender_gaps <= 1'b0;
      random_config();
      queue_motion(100);
      @(posedge clock);
      hold_wanted <= hold_wanted + 1;
      wait_meter_idle();

      for (int p = 0; p < 5; p++) begin
         sender_gaps <= $urandom_range(0, 3) != 0;
         receiver_stalls <= $urandom_range(0, 3) != 0;
         random_config();
         queue_motion(92);
         wait_meter_idle();
      end

      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("[encoder_period_speed_meter] OK");
      end else begin
         $display("[encoder_period_speed_meter] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("[encoder_period_speed_meter] ERROR");
      $finish;
   end

endmodule
